// ===== rtl/jpi_pkg.sv =====
// Shared types and constants for the jerk profile integrator.
// Used by the channel interfaces, the term unit and the top level; no dependencies.
package jpi_pkg;

    localparam int unsigned CMD_W      = 16;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned GAIN_W     = 32;
    localparam int unsigned STATE_W    = 64;
    localparam int unsigned ELAPSED_W  = 40;
    localparam int unsigned OPA_W      = 64;
    localparam int unsigned OPB_W      = 48;
    localparam int unsigned JERK_W     = 47;
    localparam int unsigned ACC_W      = 67;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_JERK_GAIN  = 2'd0,
        CFG_INIT_ACCEL = 2'd1,
        CFG_INIT_SPEED = 2'd2
    } cfg_idx_t;

    // Rounding and scaling applied by the term unit to its raw product.
    typedef enum logic [2:0] {
        MODE_RAW,
        MODE_SH15,
        MODE_SH16,
        MODE_SH32,
        MODE_SH33,
        MODE_DIV6
    } mode_t;

    typedef struct packed {
        logic              start;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
        mode_t             mode;
    } unit_req_t;

    typedef struct packed {
        logic              done;
        logic [OPA_W-1:0]  q;
    } unit_rsp_t;

    // Operation sequence of one segment.
    typedef enum logic [3:0] {
        OP_T2,
        OP_T3,
        OP_JERK,
        OP_D_SPEED,
        OP_D_ACCEL,
        OP_D_JERK,
        OP_V_ACCEL,
        OP_V_JERK,
        OP_A_JERK
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_COMMIT
    } top_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_ACC,
        U_ROUND,
        U_SHIFT,
        U_DIV,
        U_DONE
    } unit_state_t;

endpackage

// ===== rtl/jpi_seg_if.sv =====
// Input channel carrying one motion segment word.
// Depends on jpi_pkg for field widths.
interface jpi_seg_if import jpi_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CMD_W-1:0]  command;
    logic [TIME_W-1:0]        seg_time;
    logic                     final_segment;

    modport source (output valid, output command, output seg_time, output final_segment,
                    input ready);
    modport sink   (input valid, input command, input seg_time, input final_segment,
                    output ready);
endinterface

// ===== rtl/jpi_res_if.sv =====
// Output channel carrying one integrated result word.
// Depends on jpi_pkg for field widths.
interface jpi_res_if import jpi_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [STATE_W-1:0]  accel_out;
    logic signed [STATE_W-1:0]  speed_out;
    logic signed [STATE_W-1:0]  distance_out;
    logic [ELAPSED_W-1:0]       elapsed_out;
    logic                       profile_done;

    modport source (output valid, output accel_out, output speed_out, output distance_out,
                    output elapsed_out, output profile_done, input ready);
    modport sink   (input valid, input accel_out, input speed_out, input distance_out,
                    input elapsed_out, input profile_done, output ready);
endinterface

// ===== rtl/jpi_term_unit.sv =====
// Shared multiply, round and scale unit: 64x48 product from four 32x32 partial
// products, rounding shift, and an optional divide by six. Depends on jpi_pkg.
module jpi_term_unit import jpi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    localparam int unsigned PROD_W    = 96;
    localparam int unsigned DIG_W     = 8;
    localparam int unsigned QUO_W     = OPB_W;
    localparam int unsigned DIV_STEPS = QUO_W / DIG_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    unit_state_t         state_reg, state_next;
    logic [OPA_W-1:0]    a_reg;
    logic [OPB_W-1:0]    b_reg;
    mode_t               mode_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [63:0]         pp_reg;
    logic [1:0]          k_reg;
    logic [QUO_W-1:0]    dq_reg;
    logic [1:0]          rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [OPA_W-1:0]    q_reg;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [PROD_W-1:0]   pp_pos;
    logic [PROD_W-1:0]   half;
    logic [OPA_W-1:0]    q_shift;
    logic [DIG_W-1:0]    qbits;
    logic [1:0]          rem_new;
    logic [QUO_W-1:0]    dq_next;
    logic                div_last;

    // Partial product select: k[1] picks the half of a, k[0] the half of b.
    assign mul_a = k_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = k_reg[0] ? {16'd0, b_reg[47:32]} : b_reg[31:0];
    assign mul_p = mul_a * mul_b;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        case (k_reg)
            2'd0:    pp_pos = {32'd0, pp_reg};
            2'd3:    pp_pos = {pp_reg[31:0], 64'd0};
            default: pp_pos = {pp_reg, 32'd0};
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SH15: half = PROD_W'(1) << 14;
            MODE_SH16: half = PROD_W'(1) << 15;
            MODE_SH32: half = PROD_W'(1) << 31;
            MODE_SH33: half = PROD_W'(1) << 32;
            MODE_DIV6: half = PROD_W'(3) << 47;
            default:   half = '0;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SH15: q_shift = prod_reg[78:15];
            MODE_SH16: q_shift = prod_reg[79:16];
            MODE_SH32: q_shift = prod_reg[95:32];
            MODE_SH33: q_shift = {1'b0, prod_reg[95:33]};
            default:   q_shift = prod_reg[63:0];
        endcase
    end

    // Eight steps of restoring division by three on the top byte.
    always_comb
    begin
        logic [2:0] r3;
        logic [1:0] r;
        r = rem_reg;
        qbits = '0;
        for (int i = 0; i < DIG_W; i++)
        begin
            r3 = {r, dq_reg[QUO_W-1-i]};
            if (r3 >= 3'd3)
            begin
                qbits[DIG_W-1-i] = 1'b1;
                r = 2'(r3 - 3'd3);
            end
            else
            begin
                r = r3[1:0];
            end
        end
        rem_new = r;
        dq_next = {dq_reg[QUO_W-DIG_W-1:0], qbits};
    end

    always_comb
    begin
        case (state_reg)
            U_IDLE:  state_next = req.start ? U_MUL : U_IDLE;
            U_MUL:   state_next = U_ACC;
            U_ACC:   state_next = (k_reg == 2'd3) ? U_ROUND : U_MUL;
            U_ROUND: state_next = U_SHIFT;
            U_SHIFT: state_next = (mode_reg == MODE_DIV6) ? U_DIV : U_DONE;
            U_DIV:   state_next = div_last ? U_DONE : U_DIV;
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == U_DONE);
        rsp.q    = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    a_reg    <= req.a;
                    b_reg    <= req.b;
                    mode_reg <= req.mode;
                    prod_reg <= '0;
                    k_reg    <= '0;
                end
            end
            U_MUL:
            begin
                pp_reg <= mul_p;
            end
            U_ACC:
            begin
                prod_reg <= prod_reg + pp_pos;
                k_reg    <= k_reg + 2'd1;
            end
            U_ROUND:
            begin
                prod_reg <= prod_reg + half;
            end
            U_SHIFT:
            begin
                q_reg   <= q_shift;
                dq_reg  <= prod_reg[PROD_W-1:PROD_W-QUO_W];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            U_DIV:
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (div_last)
                    q_reg <= {{(OPA_W-QUO_W){1'b0}}, dq_next};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/jerk_profile_integrator.sv =====
// Jerk profile integrator. Each accepted segment word runs nine operations on the
// shared term unit (the distance jerk term with a divide by six) and three commits
// before its result word; the next segment is taken only after the final commit.
// The shared 32x32 multiplier, taking four partial products per term, sets the pace.
// Reset clears the control state, loads register reset values, and the first
// segment after reset starts a new profile.
module jerk_profile_integrator import jpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    jpi_seg_if.sink               seg,
    jpi_res_if.source             res
);

    // Configuration registers. They are sampled only at the start of a profile
    // (initial values) and during the jerk product, so writes while idle are safe.
    logic [GAIN_W-1:0]    gain_reg;
    logic [STATE_W-1:0]   init_accel_reg;
    logic [STATE_W-1:0]   init_speed_reg;

    // Sequencer state.
    top_state_t           state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 in_profile_reg;

    // Latched segment and intermediate products.
    logic [CMD_W-1:0]     cmd_reg;
    logic [TIME_W-1:0]    time_reg;
    logic                 final_reg;
    logic [31:0]          t2_reg;
    logic [47:0]          t3_reg;
    logic [JERK_W-1:0]    jmag_reg;
    logic                 jneg_reg;

    // Integrator state and the wide accumulator that sums a value with its terms.
    logic [STATE_W-1:0]   accel_reg;
    logic [STATE_W-1:0]   speed_reg;
    logic [STATE_W-1:0]   distance_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ACC_W-1:0]     acc_reg;

    // Output register, which frees the sequencer while a result waits.
    logic                 res_valid_reg;
    logic [STATE_W-1:0]   out_accel_reg;
    logic [STATE_W-1:0]   out_speed_reg;
    logic [STATE_W-1:0]   out_distance_reg;
    logic [ELAPSED_W-1:0] out_elapsed_reg;
    logic                 out_done_reg;

    unit_req_t            unit_req;
    unit_rsp_t            unit_rsp;

    logic                 accept;
    logic                 commit_ok;
    logic                 group_end;
    logic [STATE_W-1:0]   amag;
    logic [STATE_W-1:0]   smag;
    logic [GAIN_W-1:0]    gmag;
    logic [CMD_W-1:0]     cmag;
    logic                 term_neg;
    logic [ACC_W-1:0]     sterm;
    logic [STATE_W-1:0]   acc_sat;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_new;

    function automatic logic [ACC_W-1:0] widen(input logic [STATE_W-1:0] v);
        return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    jpi_term_unit u_term
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    assign seg.ready = (state_reg == S_IDLE);
    assign accept    = seg.valid && seg.ready;
    assign commit_ok = !res_valid_reg || res.ready;
    assign group_end = (op_reg == OP_D_JERK) || (op_reg == OP_V_JERK)
                       || (op_reg == OP_A_JERK);

    // Magnitudes feed the unsigned term unit; signs are applied at the accumulator.
    assign amag = accel_reg[STATE_W-1] ? (~accel_reg + STATE_W'(1)) : accel_reg;
    assign smag = speed_reg[STATE_W-1] ? (~speed_reg + STATE_W'(1)) : speed_reg;
    assign gmag = gain_reg[GAIN_W-1] ? (~gain_reg + GAIN_W'(1)) : gain_reg;
    assign cmag = cmd_reg[CMD_W-1] ? (~cmd_reg + CMD_W'(1)) : cmd_reg;

    assign sterm = term_neg ? (~{{(ACC_W-OPA_W){1'b0}}, unit_rsp.q} + ACC_W'(1))
                            : {{(ACC_W-OPA_W){1'b0}}, unit_rsp.q};

    // Saturate the accumulator to the signed 64 bit range.
    always_comb
    begin
        if ((acc_reg[ACC_W-1:STATE_W-1] == '0) || (acc_reg[ACC_W-1:STATE_W-1] == '1))
            acc_sat = acc_reg[STATE_W-1:0];
        else if (acc_reg[ACC_W-1])
            acc_sat = {1'b1, {(STATE_W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end

    assign elapsed_sum = {1'b0, elapsed_reg} + {{(ELAPSED_W+1-TIME_W){1'b0}}, time_reg};
    assign elapsed_new = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

    // Next state and next operation.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ISSUE;
                    op_next    = OP_T2;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (unit_rsp.done)
                begin
                    if (group_end)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        op_next    = op_t'(op_reg + 4'd1);
                    end
                end
            end
            S_COMMIT:
            begin
                if (op_reg == OP_A_JERK)
                begin
                    if (commit_ok)
                        state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ISSUE;
                    op_next    = op_t'(op_reg + 4'd1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Operand selection for the term unit. Distance terms come first so that they
    // see the speed and acceleration from before the segment; acceleration is last.
    always_comb
    begin
        unit_req.start = (state_reg == S_ISSUE);
        unit_req.a     = {{(OPA_W-TIME_W){1'b0}}, time_reg};
        unit_req.b     = {{(OPB_W-TIME_W){1'b0}}, time_reg};
        unit_req.mode  = MODE_RAW;
        term_neg       = 1'b0;
        case (op_reg)
            OP_T2:
            begin
            end
            OP_T3:
            begin
                unit_req.a = {32'd0, t2_reg};
            end
            OP_JERK:
            begin
                unit_req.a = {{(OPA_W-GAIN_W){1'b0}}, gmag};
                unit_req.b = {{(OPB_W-CMD_W){1'b0}}, cmag};
            end
            OP_D_SPEED:
            begin
                unit_req.a    = smag;
                unit_req.mode = MODE_SH16;
                term_neg      = speed_reg[STATE_W-1];
            end
            OP_D_ACCEL:
            begin
                unit_req.a    = amag;
                unit_req.b    = {16'd0, t2_reg};
                unit_req.mode = MODE_SH33;
                term_neg      = accel_reg[STATE_W-1];
            end
            OP_D_JERK:
            begin
                unit_req.a    = {{(OPA_W-JERK_W){1'b0}}, jmag_reg};
                unit_req.b    = t3_reg;
                unit_req.mode = MODE_DIV6;
                term_neg      = jneg_reg;
            end
            OP_V_ACCEL:
            begin
                unit_req.a    = amag;
                unit_req.mode = MODE_SH16;
                term_neg      = accel_reg[STATE_W-1];
            end
            OP_V_JERK:
            begin
                unit_req.a    = {{(OPA_W-JERK_W){1'b0}}, jmag_reg};
                unit_req.b    = {16'd0, t2_reg};
                unit_req.mode = MODE_SH32;
                term_neg      = jneg_reg;
            end
            OP_A_JERK:
            begin
                unit_req.a    = {{(OPA_W-JERK_W){1'b0}}, jmag_reg};
                unit_req.mode = MODE_SH15;
                term_neg      = jneg_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid        = res_valid_reg;
    assign res.accel_out    = out_accel_reg;
    assign res.speed_out    = out_speed_reg;
    assign res.distance_out = out_distance_reg;
    assign res.elapsed_out  = out_elapsed_reg;
    assign res.profile_done = out_done_reg;

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_T2;
            in_profile_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            gain_reg       <= GAIN_RESET;
            init_accel_reg <= '0;
            init_speed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (accept)
                in_profile_reg <= 1'b1;
            else if (state_reg == S_COMMIT && op_reg == OP_A_JERK && commit_ok && final_reg)
                in_profile_reg <= 1'b0;

            if (state_reg == S_COMMIT && op_reg == OP_A_JERK && commit_ok)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_JERK_GAIN:  gain_reg       <= cfg_data[GAIN_W-1:0];
                    CFG_INIT_ACCEL: init_accel_reg <= cfg_data;
                    CFG_INIT_SPEED: init_speed_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg   <= seg.command;
                    time_reg  <= seg.seg_time;
                    final_reg <= seg.final_segment;
                    // A segment outside a profile starts a new one from the
                    // initial registers, with distance and time at zero.
                    if (!in_profile_reg)
                    begin
                        accel_reg    <= init_accel_reg;
                        speed_reg    <= init_speed_reg;
                        distance_reg <= '0;
                        elapsed_reg  <= '0;
                        acc_reg      <= '0;
                    end
                    else
                    begin
                        acc_reg <= widen(distance_reg);
                    end
                end
            end
            S_WAIT:
            begin
                if (unit_rsp.done)
                begin
                    case (op_reg)
                        OP_T2:   t2_reg <= unit_rsp.q[31:0];
                        OP_T3:   t3_reg <= unit_rsp.q[47:0];
                        OP_JERK:
                        begin
                            jmag_reg <= unit_rsp.q[JERK_W-1:0];
                            jneg_reg <= cmd_reg[CMD_W-1] ^ gain_reg[GAIN_W-1];
                        end
                        default: acc_reg <= acc_reg + sterm;
                    endcase
                end
            end
            S_COMMIT:
            begin
                case (op_reg)
                    OP_D_JERK:
                    begin
                        distance_reg <= acc_sat;
                        acc_reg      <= widen(speed_reg);
                    end
                    OP_V_JERK:
                    begin
                        speed_reg <= acc_sat;
                        acc_reg   <= widen(accel_reg);
                    end
                    OP_A_JERK:
                    begin
                        if (commit_ok)
                        begin
                            accel_reg        <= acc_sat;
                            elapsed_reg      <= elapsed_new;
                            out_accel_reg    <= acc_sat;
                            out_speed_reg    <= speed_reg;
                            out_distance_reg <= distance_reg;
                            out_elapsed_reg  <= elapsed_new;
                            out_done_reg     <= final_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        unit_rsp.done |-> state_reg == S_WAIT)
        else $error("term unit finished while the sequencer was not waiting");

    a_accept_starts_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ISSUE) && (op_reg == OP_T2))
        else $error("accepted segment did not start the operation sequence");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_COMMIT)
                                 && ($past(op_reg) == OP_A_JERK))
        else $error("result word appeared without a final commit");
`endif

endmodule
